/* rtl/bclp_pkg.sv */
// bclp_pkg: shared types, register codes and reset constants for the
// button click / long press classifier; no dependencies
`default_nettype none

package bclp_pkg;

    localparam int TIME_WIDTH_DEFAULT = 32;
    localparam int NOW_WIDTH          = 32;
    localparam int THRESH_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH    = 2;
    localparam int IN_TDATA_WIDTH     = 40;
    localparam int OUT_TDATA_WIDTH    = 8;

    localparam logic [THRESH_WIDTH-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [THRESH_WIDTH-1:0] LONG_PRESS_RESET = 16'd2000;
    localparam logic [THRESH_WIDTH-1:0] CLICK_RESET      = 16'd300;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_INVERT_INPUT  = 2'd0,
        REG_DEBOUNCE_MS   = 2'd1,
        REG_LONG_PRESS_MS = 2'd2,
        REG_CLICK_MS      = 2'd3
    } cfg_reg_e;

    typedef struct packed {
        logic                    invert_input;
        logic [THRESH_WIDTH-1:0] debounce_ms;
        logic [THRESH_WIDTH-1:0] long_press_ms;
        logic [THRESH_WIDTH-1:0] click_ms;
    } cfg_t;

    // packed from msb down, so level lands in bit 0
    typedef struct packed {
        logic changed;
        logic double_click_event;
        logic click_event;
        logic long_press_event;
        logic fall_event;
        logic rise_event;
        logic level;
    } result_t;

endpackage

`default_nettype wire

/* rtl/bclp_classify.sv */
// bclp_classify: debounce state and event decisions for one request per cycle
// depends on bclp_pkg
`default_nettype none

module bclp_classify #(
    parameter int TIME_WIDTH = bclp_pkg::TIME_WIDTH_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire bclp_pkg::cfg_t                     cfg,
    input  wire logic                               step,
    input  wire logic                               pin_level,
    input  wire logic [bclp_pkg::NOW_WIDTH-1:0]     now_ms,
    output bclp_pkg::result_t                       result
);

    logic                  stable_level_reg, stable_level_next;
    logic [TIME_WIDTH-1:0] last_change_reg, last_change_next;
    logic                  long_held_reg, long_held_next;
    logic                  click_pending_reg, click_pending_next;

    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] elapsed;
    logic [TIME_WIDTH-1:0] debounce_t;
    logic [TIME_WIDTH-1:0] long_press_t;
    logic [TIME_WIDTH-1:0] click_t;
    logic                  lvl;
    logic                  sample;

    assign now_t        = TIME_WIDTH'(now_ms);
    assign elapsed      = now_t - last_change_reg;
    assign debounce_t   = TIME_WIDTH'(cfg.debounce_ms);
    assign long_press_t = TIME_WIDTH'(cfg.long_press_ms);
    assign click_t      = TIME_WIDTH'(cfg.click_ms);
    assign lvl          = pin_level ^ cfg.invert_input;
    assign sample       = step && (elapsed >= debounce_t);

    always_comb
    begin
        stable_level_next  = stable_level_reg;
        last_change_next   = last_change_reg;
        long_held_next     = long_held_reg;
        click_pending_next = click_pending_reg;
        result             = '0;
        if (sample)
        begin
            if (lvl)
            begin
                if (!stable_level_reg)
                begin
                    stable_level_next = 1'b1;
                    last_change_next  = now_t;
                    result.rise_event = 1'b1;
                end
                else if ((elapsed > long_press_t) && !long_held_reg)
                begin
                    long_held_next          = 1'b1;
                    result.long_press_event = 1'b1;
                end
            end
            else if (stable_level_reg)
            begin
                // release: elapsed restarts at zero, so no click report here
                stable_level_next = 1'b0;
                last_change_next  = now_t;
                long_held_next    = 1'b0;
                result.fall_event = 1'b1;
                if (elapsed < click_t)
                begin
                    if (click_pending_reg)
                    begin
                        click_pending_next        = 1'b0;
                        result.double_click_event = 1'b1;
                    end
                    else
                    begin
                        click_pending_next = 1'b1;
                    end
                end
            end
            else if ((elapsed > click_t) && click_pending_reg)
            begin
                click_pending_next = 1'b0;
                result.click_event = 1'b1;
            end
        end
        result.level   = stable_level_next;
        result.changed = result.rise_event | result.fall_event | result.long_press_event
                       | result.click_event | result.double_click_event;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_level_reg  <= 1'b0;
            last_change_reg   <= '0;
            long_held_reg     <= 1'b0;
            click_pending_reg <= 1'b0;
        end
        else if (step)
        begin
            stable_level_reg  <= stable_level_next;
            last_change_reg   <= last_change_next;
            long_held_reg     <= long_held_next;
            click_pending_reg <= click_pending_next;
        end
    end

    a_rise_sets_level: assert property (@(posedge clk) disable iff (!rst_n)
        result.rise_event |=> stable_level_reg)
        else $error("rise event did not raise the stable level");

    a_fall_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result.fall_event |=> (!stable_level_reg && !long_held_reg))
        else $error("fall event left level or long hold set");

    a_double_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (result.double_click_event || result.click_event) |=> !click_pending_reg)
        else $error("click report left a pending click");

    a_one_long_press: assert property (@(posedge clk) disable iff (!rst_n)
        result.long_press_event |=> long_held_reg)
        else $error("long press event without hold flag");

    a_hold_needs_level: assert property (@(posedge clk) disable iff (!rst_n)
        long_held_reg |-> stable_level_reg)
        else $error("long hold flag set while level is low");

endmodule

`default_nettype wire

/* rtl/button_click_long_press_classifier_unit.sv */
// button_click_long_press_classifier_unit: top level with config registers,
// input register and result register; depends on bclp_pkg, bclp_classify
//
//  channel   dir  handshake          payload (lsb first)
//  s_*       in   s_tvalid/s_tready  s_tdata: pin_level, now_ms[31:0], zero pad
//  m_*       out  m_tvalid/m_tready  m_tdata: level, rise, fall, long_press,
//                                             click, double_click, changed, 0
//  cfg_*     in   cfg_we             cfg_index selects register, cfg_data value
//
//  one request per cycle sustained while m_tready accepts; s_tdata reaches m_tdata
//  through the input register, then the classifier into the result register
//  the classifier state updates once per request, so each cycle sees the last
//  reset clears state and config to defaults; no clearing pass
//  a stalled m_tready holds the result and backs up into s_tready after one
`default_nettype none

module button_click_long_press_classifier_unit #(
    parameter int TIME_WIDTH = bclp_pkg::TIME_WIDTH_DEFAULT
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    s_tvalid,
    output logic                                         s_tready,
    input  wire logic [bclp_pkg::IN_TDATA_WIDTH-1:0]     s_tdata,   // pin_level, now_ms
    output logic                                         m_tvalid,
    input  wire logic                                    m_tready,
    output logic [bclp_pkg::OUT_TDATA_WIDTH-1:0]         m_tdata,   // level, rise, fall,
                                                                    // long_press, click,
                                                                    // double_click, changed
    input  wire logic                                    cfg_we,
    input  wire logic [bclp_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  wire logic [bclp_pkg::THRESH_WIDTH-1:0]       cfg_data
);

    bclp_pkg::cfg_t                       cfg_reg;
    logic                                 in_valid_reg;
    logic                                 in_level_reg;
    logic [bclp_pkg::NOW_WIDTH-1:0]       in_time_reg;
    logic                                 out_valid_reg;
    bclp_pkg::result_t                    out_data_reg;
    bclp_pkg::result_t                    result;
    logic                                 advance;
    logic                                 step;
    logic                                 s_take;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.invert_input  <= 1'b0;
            cfg_reg.debounce_ms   <= bclp_pkg::DEBOUNCE_RESET;
            cfg_reg.long_press_ms <= bclp_pkg::LONG_PRESS_RESET;
            cfg_reg.click_ms      <= bclp_pkg::CLICK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (bclp_pkg::cfg_reg_e'(cfg_index))
                bclp_pkg::REG_INVERT_INPUT:  cfg_reg.invert_input  <= cfg_data[0];
                bclp_pkg::REG_DEBOUNCE_MS:   cfg_reg.debounce_ms   <= cfg_data;
                bclp_pkg::REG_LONG_PRESS_MS: cfg_reg.long_press_ms <= cfg_data;
                bclp_pkg::REG_CLICK_MS:      cfg_reg.click_ms      <= cfg_data;
                default:                     cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_level_reg <= s_tdata[0];
            in_time_reg  <= s_tdata[bclp_pkg::NOW_WIDTH:1];
        end
    end

    bclp_classify #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .step      (step),
        .pin_level (in_level_reg),
        .now_ms    (in_time_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = bclp_pkg::OUT_TDATA_WIDTH'(out_data_reg);

endmodule

`default_nettype wire

/* tb/button_click_long_press_classifier_unit_test.sv */
// testbench for button_click_long_press_classifier_unit: directed and random button
// gestures checked against an in-bench classifier; depends on bclp_pkg and the rtl top
`default_nettype none

module button_click_long_press_classifier_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [bclp_pkg::IN_TDATA_WIDTH-1:0]  s_tdata;    // pin_level, now_ms, zero pad
    logic                                 m_tvalid;
    logic                                 m_tready = 1'b0;
    logic [bclp_pkg::OUT_TDATA_WIDTH-1:0] m_tdata;    // level, rise, fall, long_press, click,
                                                      // double_click, changed, zero pad
    logic                                 cfg_we;
    logic [bclp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [bclp_pkg::THRESH_WIDTH-1:0]    cfg_data;

    // classifier copy kept by the bench
    logic                              mdl_invert;
    logic [bclp_pkg::THRESH_WIDTH-1:0] mdl_debounce;
    logic [bclp_pkg::THRESH_WIDTH-1:0] mdl_long_press;
    logic [bclp_pkg::THRESH_WIDTH-1:0] mdl_click;
    logic                              mdl_level;
    logic [bclp_pkg::NOW_WIDTH-1:0]    mdl_last_change;
    logic                              mdl_long_held;
    logic                              mdl_click_pending;

    bclp_pkg::result_t expected_results[$];
    bclp_pkg::result_t want;
    bclp_pkg::result_t got;
    logic [31:0]       wall_ms;
    int unsigned       samples_sent;
    int unsigned       results_checked;
    int unsigned       mismatches;
    int unsigned       settings_used;
    int unsigned       stall_cycles;
    int unsigned       send_idle_pct;
    int unsigned       recv_idle_pct;

    button_click_long_press_classifier_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic bclp_pkg::result_t classify_sample(logic pin,
                                                          logic [bclp_pkg::NOW_WIDTH-1:0] now);
        bclp_pkg::result_t              r;
        logic                           lvl;
        logic [bclp_pkg::NOW_WIDTH-1:0] held;
        r    = '0;
        lvl  = pin ^ mdl_invert;
        held = now - mdl_last_change;
        if (held >= mdl_debounce)
        begin
            if (lvl)
            begin
                if (!mdl_level)
                begin
                    mdl_level       = 1'b1;
                    r.rise_event    = 1'b1;
                    mdl_last_change = now;
                end
                else if (held > mdl_long_press && !mdl_long_held)
                begin
                    mdl_long_held      = 1'b1;
                    r.long_press_event = 1'b1;
                end
            end
            else
            begin
                if (mdl_level)
                begin
                    mdl_level     = 1'b0;
                    r.fall_event  = 1'b1;
                    mdl_long_held = 1'b0;
                    if (held < mdl_click)
                    begin
                        if (mdl_click_pending)
                        begin
                            r.double_click_event = 1'b1;
                            mdl_click_pending    = 1'b0;
                        end
                        else
                        begin
                            mdl_click_pending = 1'b1;
                        end
                    end
                    mdl_last_change = now;
                    held            = '0;
                end
                if (held > mdl_click && mdl_click_pending)
                begin
                    r.click_event     = 1'b1;
                    mdl_click_pending = 1'b0;
                end
            end
        end
        r.level   = mdl_level;
        r.changed = r.rise_event | r.fall_event | r.long_press_event | r.click_event
                  | r.double_click_event;
        return r;
    endfunction

    task automatic check_bit(string name, logic exp_bit, logic act_bit);
        if (exp_bit !== act_bit)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_bit, act_bit);
            mismatches++;
        end
    endtask

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got = bclp_pkg::result_t'(m_tdata[6:0]);
            if (expected_results.size() == 0)
            begin
                $error("result with no request waiting: m_tdata %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_bit("level", want.level, got.level);
                check_bit("rise_event", want.rise_event, got.rise_event);
                check_bit("fall_event", want.fall_event, got.fall_event);
                check_bit("long_press_event", want.long_press_event, got.long_press_event);
                check_bit("click_event", want.click_event, got.click_event);
                check_bit("double_click_event", want.double_click_event,
                          got.double_click_event);
                check_bit("changed", want.changed, got.changed);
                results_checked++;
            end
        end
    end

    initial
    begin : watchdog
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic send_sample(logic pin, logic [bclp_pkg::NOW_WIDTH-1:0] now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(bclp_pkg::IN_TDATA_WIDTH-bclp_pkg::NOW_WIDTH-1){1'b0}}, now, pin};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(classify_sample(pin, now));
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic write_reg(bclp_pkg::cfg_reg_e idx, logic [bclp_pkg::THRESH_WIDTH-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            bclp_pkg::REG_INVERT_INPUT:  mdl_invert     = val[0];
            bclp_pkg::REG_DEBOUNCE_MS:   mdl_debounce   = val;
            bclp_pkg::REG_LONG_PRESS_MS: mdl_long_press = val;
            bclp_pkg::REG_CLICK_MS:      mdl_click      = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_config(logic inv, logic [bclp_pkg::THRESH_WIDTH-1:0] deb,
                                logic [bclp_pkg::THRESH_WIDTH-1:0] lp,
                                logic [bclp_pkg::THRESH_WIDTH-1:0] ck);
        drain_results();
        write_reg(bclp_pkg::REG_INVERT_INPUT, {{(bclp_pkg::THRESH_WIDTH-1){1'b0}}, inv});
        write_reg(bclp_pkg::REG_DEBOUNCE_MS, deb);
        write_reg(bclp_pkg::REG_LONG_PRESS_MS, lp);
        write_reg(bclp_pkg::REG_CLICK_MS, ck);
        settings_used++;
    endtask

    // holds a debounced level for a span of ms, with bounce right after the change
    task automatic hold_level(logic lvl, int unsigned span);
        int unsigned spent;
        int unsigned stride;
        logic        pin;
        spent = 0;
        while (spent < span)
        begin
            stride  = $urandom_range(1, mdl_click / 3 + 1);
            spent  += stride;
            wall_ms += stride;
            pin = lvl;
            if (spent <= mdl_debounce && $urandom_range(3) == 0)
                pin = ~lvl;
            send_sample(pin ^ mdl_invert, wall_ms);
        end
    endtask

    task automatic test_reset_defaults();
        send_sample(1'b1, 32'd0);
        send_sample(1'b1, 32'd50);
        send_sample(1'b0, 32'd60);
        send_sample(1'b1, 32'd2050);
        send_sample(1'b1, 32'd2051);
        send_sample(1'b0, 32'd5100);
        send_sample(1'b1, 32'd5150);
        send_sample(1'b0, 32'd5300);
        send_sample(1'b0, 32'd5600);
        send_sample(1'b0, 32'd5601);
        send_sample(1'b1, 32'd5700);
        send_sample(1'b0, 32'd5800);
        send_sample(1'b1, 32'd5850);
        send_sample(1'b0, 32'd5900);
    endtask

    task automatic test_time_wrap();
        apply_config(1'b1, 16'd100, 16'd1000, 16'd500);
        send_sample(1'b1, 32'hFFFF_FF00);
        send_sample(1'b0, 32'hFFFF_FFF0);
        send_sample(1'b0, 32'h0000_0100);
        send_sample(1'b1, 32'h0000_0150);
        send_sample(1'b1, 32'h0000_0400);
        send_sample(1'b0, 32'hFFFF_FFFF);
    endtask

    task automatic test_zero_thresholds();
        apply_config(1'b0, 16'd0, 16'd0, 16'd0);
        send_sample(1'b0, 32'd0);
        send_sample(1'b1, 32'd0);
        send_sample(1'b1, 32'd0);
        send_sample(1'b1, 32'd1);
        send_sample(1'b0, 32'd1);
    endtask

    task automatic test_max_thresholds();
        logic [bclp_pkg::NOW_WIDTH-1:0] t;
        apply_config(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        t = mdl_last_change + 32'd65534;
        send_sample(1'b1, t);
        t = t + 32'd1;
        send_sample(1'b1, t);
        t = t + 32'd65536;
        send_sample(1'b1, t);
        t = t + 32'd65535;
        send_sample(1'b0, t);
    endtask

    task automatic test_random_gestures(int unsigned count, bit pause_midway);
        int unsigned stop_at;
        int unsigned half_at;
        int unsigned kind;
        int unsigned deb;
        int unsigned ck;
        bit          paused;
        deb = $urandom_range(0, 8);
        ck  = $urandom_range(deb + 4, 60);
        apply_config(1'($urandom_range(0, 1)), bclp_pkg::THRESH_WIDTH'(deb),
                     bclp_pkg::THRESH_WIDTH'($urandom_range(ck, 160)),
                     bclp_pkg::THRESH_WIDTH'(ck));
        wall_ms = $urandom();
        stop_at = samples_sent + count;
        half_at = samples_sent + count / 2;
        paused  = 1'b0;
        while (samples_sent < stop_at)
        begin
            if (pause_midway && !paused && samples_sent >= half_at)
            begin
                drain_results();
                paused = 1'b1;
            end
            kind = $urandom_range(0, 9);
            case (kind) inside
                [0:3]:
                begin
                    hold_level(1'b1, $urandom_range(1, mdl_click));
                    hold_level(1'b0, $urandom_range(1, 3 * mdl_click));
                end
                [4:5]:
                begin
                    hold_level(1'b1, $urandom_range(1, mdl_click));
                    hold_level(1'b0, $urandom_range(1, mdl_click));
                    hold_level(1'b1, $urandom_range(1, mdl_click));
                    hold_level(1'b0, $urandom_range(mdl_click, 3 * mdl_click));
                end
                [6:7]:
                begin
                    hold_level(1'b1, $urandom_range(mdl_long_press, 2 * mdl_long_press + 20));
                    hold_level(1'b0, $urandom_range(1, 2 * mdl_click));
                end
                8:
                begin
                    repeat ($urandom_range(2, 8))
                    begin
                        wall_ms += $urandom_range(0, 3);
                        send_sample(1'($urandom_range(0, 1)), wall_ms);
                    end
                end
                default:
                begin
                    wall_ms += $urandom();
                    send_sample(1'($urandom_range(0, 1)), wall_ms);
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = bclp_pkg::REG_INVERT_INPUT;
        cfg_data  = '0;

        mdl_invert        = 1'b0;
        mdl_debounce      = bclp_pkg::DEBOUNCE_RESET;
        mdl_long_press    = bclp_pkg::LONG_PRESS_RESET;
        mdl_click         = bclp_pkg::CLICK_RESET;
        mdl_level         = 1'b0;
        mdl_last_change   = '0;
        mdl_long_held     = 1'b0;
        mdl_click_pending = 1'b0;

        samples_sent    = 0;
        results_checked = 0;
        mismatches      = 0;
        settings_used   = 1;
        wall_ms         = '0;
        send_idle_pct   = 16;
        recv_idle_pct   = 45;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_time_wrap();
        test_zero_thresholds();
        test_max_thresholds();

        for (int mode = 0; mode < 3; mode++)
        begin
            drain_results();
            case (mode)
                0:       begin send_idle_pct = 16; recv_idle_pct = 45; end
                1:       begin send_idle_pct = 45; recv_idle_pct = 16; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            test_random_gestures(155, mode == 0);
            test_random_gestures(155, 1'b0);
        end

        drain_results();
        repeat (10) @(negedge clk);

        $display("checked %0d results from %0d samples under %0d register settings",
                 results_checked, samples_sent, settings_used);
        $display("covered debounce, edges, long press, click, double click, wrap, idling mixes");
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
